// ===== design/bltl_pkg.sv =====
// shared types and constants for the blinking traffic light sequencer
package bltl_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_GREEN_HALVES  = 3'd0,
      REG_YELLOW_HALVES = 3'd1,
      REG_RED_HALVES    = 3'd2,
      REG_STEP_PERIOD   = 3'd3,
      REG_DEBOUNCE      = 3'd4
   } reg_index_type;

   // phase codes
   typedef enum logic [1:0] {
      PHASE_GREEN  = 2'd0,
      PHASE_YELLOW = 2'd1,
      PHASE_RED    = 2'd2,
      PHASE_SPARE  = 2'd3
   } phase_type;

   // lamp bit positions: bit 0 red, bit 1 yellow, bit 2 green
   localparam logic [2:0] LAMP_RED    = 3'b001;
   localparam logic [2:0] LAMP_YELLOW = 3'b010;
   localparam logic [2:0] LAMP_GREEN  = 3'b100;

   // register reset values
   localparam logic [7:0]  GREEN_HALVES_RST  = 8'd14;
   localparam logic [7:0]  YELLOW_HALVES_RST = 8'd6;
   localparam logic [7:0]  RED_HALVES_RST    = 8'd10;
   localparam logic [15:0] STEP_PERIOD_RST   = 16'd500;
   localparam logic [15:0] DEBOUNCE_RST      = 16'd300;

   // configuration seen by the sequencer
   typedef struct packed {
      logic [7:0]  green_halves;
      logic [7:0]  yellow_halves;
      logic [7:0]  red_halves;
      logic [15:0] step_period_ms;
      logic [15:0] debounce_ms;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic       system_on;
      logic       display_update;
      logic [7:0] display_value;
      logic       display_blank;
      logic       green_on;
      logic       yellow_on;
      logic       red_on;
   } result_type;

endpackage

// ===== design/bltl_seq.sv =====
// sequencer state and the per-tick update
module bltl_seq
   import bltl_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       tick_valid,
   input  logic       button_level,
   output result_type result
);

   localparam int LW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

   logic                   enabled_ff, enabled_in;
   logic                   prev_button_ff, prev_button_in;
   logic [TIMER_WIDTH-1:0] debounce_ff, debounce_in;
   logic [TIMER_WIDTH-1:0] step_ff, step_in;
   phase_type              phase_ff, phase_in;
   logic [7:0]             halves_ff, halves_in;
   logic                   lit_ff, lit_in;
   logic [7:0]             seconds_ff, seconds_in;
   logic [2:0]             lamps_ff, lamps_in;
   logic [7:0]             shown_ff, shown_in;

   logic [LW-1:0]          deb_ext, step_ext;
   logic [TIMER_WIDTH-1:0] deb_lim, step_lim, deb_tick, step_tick;
   logic                   toggle, update;
   logic [7:0]             cur_halves, next_halves, halves_dec;
   logic [2:0]             cur_lamp;
   phase_type              next_phase;

   // period clamped to the timer range
   always_comb begin
      deb_ext  = LW'(cfg.debounce_ms);
      step_ext = LW'(cfg.step_period_ms);
      deb_lim  = ((deb_ext >> TIMER_WIDTH) != '0) ? '1 : deb_ext[TIMER_WIDTH-1:0];
      step_lim = ((step_ext >> TIMER_WIDTH) != '0) ? '1 : step_ext[TIMER_WIDTH-1:0];
      deb_tick  = (debounce_ff >= deb_lim) ? deb_lim : debounce_ff + 1'b1;
      step_tick = (step_ff >= step_lim) ? step_lim : step_ff + 1'b1;
   end

   // phase length and lamp of the current phase
   always_comb begin
      case (phase_ff)
         PHASE_GREEN: begin
            cur_halves = cfg.green_halves;
            cur_lamp   = LAMP_GREEN;
            next_phase = PHASE_YELLOW;
         end
         PHASE_YELLOW: begin
            cur_halves = cfg.yellow_halves;
            cur_lamp   = LAMP_YELLOW;
            next_phase = PHASE_RED;
         end
         default: begin
            cur_halves = cfg.red_halves;
            cur_lamp   = LAMP_RED;
            next_phase = PHASE_GREEN;
         end
      endcase
      case (next_phase)
         PHASE_GREEN:  next_halves = cfg.green_halves;
         PHASE_YELLOW: next_halves = cfg.yellow_halves;
         default:      next_halves = cfg.red_halves;
      endcase
   end

   // button handling and one sequencer step
   always_comb begin
      toggle         = prev_button_ff && !button_level && (deb_tick >= deb_lim);
      enabled_in     = enabled_ff ^ toggle;
      debounce_in    = toggle ? '0 : deb_tick;
      prev_button_in = button_level;
      step_in        = step_tick;
      phase_in       = phase_ff;
      halves_in      = halves_ff;
      lit_in         = lit_ff;
      seconds_in     = seconds_ff;
      lamps_in       = lamps_ff;
      shown_in       = shown_ff;
      update         = 1'b0;
      halves_dec     = halves_ff - 8'd1;
      if (enabled_in) begin
         if (step_tick >= step_lim) begin
            step_in = '0;
            if (halves_ff == cur_halves) begin
               seconds_in = {1'b0, cur_halves[7:1]} - 8'd1;
               lit_in     = 1'b1;
               lamps_in   = cur_lamp;
            end else begin
               lit_in   = !lit_ff;
               lamps_in = lit_in ? (lamps_ff | cur_lamp) : (lamps_ff & ~cur_lamp);
            end
            if (lit_in) begin
               shown_in   = seconds_in;
               update     = 1'b1;
               seconds_in = seconds_in - 8'd1;
            end
            halves_in = halves_dec;
            if (halves_dec == 8'd0) begin
               phase_in  = next_phase;
               halves_in = next_halves;
            end
         end
      end else begin
         lamps_in = 3'b000;
      end
   end

   // result of this tick
   always_comb begin
      result.red_on         = lamps_in[0];
      result.yellow_on      = lamps_in[1];
      result.green_on       = lamps_in[2];
      result.display_blank  = !enabled_in;
      result.display_value  = shown_in;
      result.display_update = update;
      result.system_on      = enabled_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b1;
         prev_button_ff <= 1'b1;
         debounce_ff    <= '0;
         step_ff        <= '0;
         phase_ff       <= PHASE_GREEN;
         halves_ff      <= GREEN_HALVES_RST;
         lit_ff         <= 1'b0;
         seconds_ff     <= 8'd0;
         lamps_ff       <= 3'b000;
         shown_ff       <= 8'd0;
      end else if (tick_valid) begin
         enabled_ff     <= enabled_in;
         prev_button_ff <= prev_button_in;
         debounce_ff    <= debounce_in;
         step_ff        <= step_in;
         phase_ff       <= phase_in;
         halves_ff      <= halves_in;
         lit_ff         <= lit_in;
         seconds_ff     <= seconds_in;
         lamps_ff       <= lamps_in;
         shown_ff       <= shown_in;
      end
   end

endmodule

// ===== design/blinking_traffic_light_sequencer.sv =====
// top level: configuration registers, sequencer and output buffer
//
// channel  direction  fields
// req_     in         tdata[0] button_level
// rsp_     out        tdata[13:0] lamps, blank, display value, update, system_on
// csr_     in         index, wdata (register write)
//
// one tick item is taken per cycle while the skid entry is empty; its result
// is registered into a two-entry output buffer (main plus skid), which keeps
// req_tready registered, so input continues while one result waits.
// reset restores the configuration registers, sequencer state and buffer valid
// flags; buffer data is not reset. csr writes are always taken.
module blinking_traffic_light_sequencer
   import bltl_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] button_level, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] red_on, [1] yellow_on, [2] green_on,
                                    // [3] display_blank, [11:4] display_value,
                                    // [12] display_update, [13] system_on
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   result_type result;
   result_type main_ff, skid_ff;
   logic       main_valid_ff, skid_valid_ff;
   logic       push, pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_halves   <= GREEN_HALVES_RST;
         cfg_ff.yellow_halves  <= YELLOW_HALVES_RST;
         cfg_ff.red_halves     <= RED_HALVES_RST;
         cfg_ff.step_period_ms <= STEP_PERIOD_RST;
         cfg_ff.debounce_ms    <= DEBOUNCE_RST;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_GREEN_HALVES:  cfg_ff.green_halves   <= csr_wdata[7:0];
            REG_YELLOW_HALVES: cfg_ff.yellow_halves  <= csr_wdata[7:0];
            REG_RED_HALVES:    cfg_ff.red_halves     <= csr_wdata[7:0];
            REG_STEP_PERIOD:   cfg_ff.step_period_ms <= csr_wdata;
            REG_DEBOUNCE:      cfg_ff.debounce_ms    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input transfer
   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = main_valid_ff && rsp_tready;

   bltl_seq #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .tick_valid   (push),
      .button_level (req_tdata[0]),
      .result       (result)
   );

   // output buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || pop) begin
         main_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= skid_valid_ff && push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // output buffer data
   always_ff @(posedge clock) begin
      if (!main_valid_ff || pop) begin
         main_ff <= skid_valid_ff ? skid_ff : result;
         if (skid_valid_ff) begin
            skid_ff <= result;
         end
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {2'b00, main_ff};

endmodule

// ===== tb/tb_blinking_traffic_light_sequencer.sv =====
// self-checking testbench for the blinking traffic light sequencer
module tb_blinking_traffic_light_sequencer;
   timeunit 1ns;
   timeprecision 1ps;
   import bltl_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [0] button_level, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [0] red_on, [1] yellow_on, [2] green_on,
                                    // [3] display_blank, [11:4] display_value,
                                    // [12] display_update, [13] system_on
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int cycle_count = 0;
   int error_count = 0;
   bit idle_mode = 1'b1;

   // predicted lamp and display state
   cfg_type     light_cfg;
   bit          lights_on;
   bit          last_button;
   int unsigned press_timer;
   int unsigned step_timer;
   phase_type   cur_phase;
   logic [7:0]  halves_left;
   bit          lamp_lit;
   logic [7:0]  seconds_left;
   logic [2:0]  lamps;
   logic [7:0]  shown_value;
   result_type  pending_lights[$];

   blinking_traffic_light_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial forever #1 clock = ~clock;

   // cycle counter guarding against a hang
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= 60)
         $display("mismatch at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
   endtask

   function automatic int unsigned saturate_timer(int unsigned count, logic [15:0] limit);
      return (count >= limit) ? limit : count + 1;
   endfunction

   function automatic logic [7:0] phase_span(phase_type p);
      case (p)
         PHASE_GREEN:  return light_cfg.green_halves;
         PHASE_YELLOW: return light_cfg.yellow_halves;
         default:      return light_cfg.red_halves;
      endcase
   endfunction

   // advance the lamp state by one millisecond tick
   function automatic result_type predict_tick(bit button);
      result_type r;
      logic [7:0] span;
      logic [2:0] lamp_bit;
      bit         shown_now;
      shown_now = 1'b0;
      press_timer = saturate_timer(press_timer, light_cfg.debounce_ms);
      step_timer = saturate_timer(step_timer, light_cfg.step_period_ms);

      // falling edge toggles enable once the debounce time has passed
      if (last_button && !button && press_timer >= light_cfg.debounce_ms) begin
         lights_on = !lights_on;
         press_timer = 0;
      end
      last_button = button;

      if (lights_on) begin
         if (step_timer >= light_cfg.step_period_ms) begin
            span = phase_span(cur_phase);
            case (cur_phase)
               PHASE_GREEN:  lamp_bit = LAMP_GREEN;
               PHASE_YELLOW: lamp_bit = LAMP_YELLOW;
               default:      lamp_bit = LAMP_RED;
            endcase
            step_timer = 0;
            // phase entry when the remaining count matches the register
            if (halves_left == span) begin
               seconds_left = (span >> 1) - 8'd1;
               lamp_lit = 1'b1;
               lamps = lamp_bit;
            end else begin
               lamp_lit = !lamp_lit;
               lamps = lamp_lit ? (lamps | lamp_bit) : (lamps & ~lamp_bit);
            end
            if (lamp_lit) begin
               shown_value = seconds_left;
               shown_now = 1'b1;
               seconds_left = seconds_left - 8'd1;
            end
            halves_left = halves_left - 8'd1;
            if (halves_left == 8'd0) begin
               case (cur_phase)
                  PHASE_GREEN:  cur_phase = PHASE_YELLOW;
                  PHASE_YELLOW: cur_phase = PHASE_RED;
                  default:      cur_phase = PHASE_GREEN;
               endcase
               halves_left = phase_span(cur_phase);
            end
         end
      end else begin
         lamps = '0;
      end

      r.red_on = lamps[0];
      r.yellow_on = lamps[1];
      r.green_on = lamps[2];
      r.display_blank = !lights_on;
      r.display_value = shown_value;
      r.display_update = shown_now;
      r.system_on = lights_on;
      return r;
   endfunction

   // one tick transfer, with an occasional random gap ahead of it in idle mode
   task automatic send_tick(bit button);
      int gap;
      if (idle_mode && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, button};
      do @(posedge clock); while (!req_tready);
      pending_lights.push_back(predict_tick(button));
      @(negedge clock);
   endtask

   // hold off the sender until every expected result is in
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_lights.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_GREEN_HALVES:  light_cfg.green_halves = value[7:0];
         REG_YELLOW_HALVES: light_cfg.yellow_halves = value[7:0];
         REG_RED_HALVES:    light_cfg.red_halves = value[7:0];
         REG_STEP_PERIOD:   light_cfg.step_period_ms = value;
         REG_DEBOUNCE:      light_cfg.debounce_ms = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // write all registers while idle, optionally switching the lights on first
   task automatic set_lights(cfg_type wanted, bit power_on);
      logic [7:0] junk;
      wait_drained();
      if (power_on && !lights_on) begin
         write_reg(REG_DEBOUNCE, 16'd0);
         csr_valid <= 1'b0;
         send_tick(1'b1);
         send_tick(1'b0);
         send_tick(1'b1);
         wait_drained();
      end
      // upper byte of the phase registers is junk and must be dropped
      junk = 8'($urandom);
      write_reg(REG_GREEN_HALVES, {junk, wanted.green_halves});
      junk = 8'($urandom);
      write_reg(REG_YELLOW_HALVES, {junk, wanted.yellow_halves});
      junk = 8'($urandom);
      write_reg(REG_RED_HALVES, {junk, wanted.red_halves});
      write_reg(REG_STEP_PERIOD, wanted.step_period_ms);
      write_reg(REG_DEBOUNCE, wanted.debounce_ms);
      csr_valid <= 1'b0;
   endtask

   // press and release runs with the odd single-tick glitch
   task automatic random_buttons(int count, bit pause_midway);
      int sent;
      int run;
      bit level;
      sent = 0;
      level = 1'b1;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) run = 1;
         else if (level) run = $urandom_range(1, 60);
         else run = $urandom_range(1, 8);
         while (run > 0 && sent < count) begin
            send_tick(level);
            sent++;
            run--;
         end
         level = !level;
         if (pause_midway && sent >= count / 2) begin
            wait_drained();
            pause_midway = 1'b0;
         end
      end
   endtask

   // reset values, early press ignored by the debounce timer
   task automatic test_power_on_defaults();
      bit presses[10] = '{1, 1, 1, 1, 1, 1, 0, 0, 1, 1};
      foreach (presses[i]) send_tick(presses[i]);
   endtask

   // longest step period and debounce: nothing may happen
   task automatic test_register_extremes();
      set_lights({8'd1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF}, 1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // no debounce, step every tick, a one-step green phase with countdown wrap
   task automatic test_toggle_fast_steps();
      bit presses[10] = '{1, 0, 1, 1, 0, 0, 1, 1, 1, 1};
      set_lights({8'd1, 8'd2, 8'd3, 16'd0, 16'd0}, 1'b0);
      foreach (presses[i]) send_tick(presses[i]);
   endtask

   // short random phase lengths and periods, toggling freely
   task automatic test_random_short_phases();
      cfg_type pick;
      int k;
      for (k = 0; k < 4; k++) begin
         pick.green_halves = 8'($urandom_range(1, 9));
         pick.yellow_halves = 8'($urandom_range(1, 9));
         pick.red_halves = 8'($urandom_range(1, 9));
         pick.step_period_ms = 16'($urandom_range(0, 4));
         pick.debounce_ms = 16'($urandom_range(0, 40));
         idle_mode = (k != 2);
         set_lights(pick, 1'b0);
         random_buttons(70, k == 0);
      end
   endtask

   // zero green length wraps to 256 steps
   task automatic test_zero_phase_length();
      idle_mode = 1'b1;
      set_lights({8'd0, 8'd1, 8'd1, 16'd0, 16'hFFFF}, 1'b1);
      random_buttons(120, 1'b0);
   endtask

   // longest green phase, countdown starts at its maximum; no idling
   task automatic test_longest_phase();
      idle_mode = 1'b0;
      set_lights({8'd255, 8'd1, 8'd1, 16'd0, 16'hFFFF}, 1'b1);
      random_buttons(320, 1'b0);
   endtask

   // random stalls on the result side
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (idle_mode && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[13:0];
         if (pending_lights.size() == 0) begin
            report_mismatch("unexpected result", seen, 0);
         end else begin
            want = pending_lights.pop_front();
            if (seen.red_on !== want.red_on)
               report_mismatch("red_on", seen.red_on, want.red_on);
            if (seen.yellow_on !== want.yellow_on)
               report_mismatch("yellow_on", seen.yellow_on, want.yellow_on);
            if (seen.green_on !== want.green_on)
               report_mismatch("green_on", seen.green_on, want.green_on);
            if (seen.display_blank !== want.display_blank)
               report_mismatch("display_blank", seen.display_blank, want.display_blank);
            if (seen.display_value !== want.display_value)
               report_mismatch("display_value", seen.display_value, want.display_value);
            if (seen.display_update !== want.display_update)
               report_mismatch("display_update", seen.display_update, want.display_update);
            if (seen.system_on !== want.system_on)
               report_mismatch("system_on", seen.system_on, want.system_on);
         end
      end
   end

   initial begin
      light_cfg = {GREEN_HALVES_RST, YELLOW_HALVES_RST, RED_HALVES_RST,
                   STEP_PERIOD_RST, DEBOUNCE_RST};
      lights_on = 1'b1;
      last_button = 1'b1;
      press_timer = 0;
      step_timer = 0;
      cur_phase = PHASE_GREEN;
      halves_left = GREEN_HALVES_RST;
      lamp_lit = 1'b0;
      seconds_left = '0;
      lamps = '0;
      shown_value = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on_defaults();
      test_register_extremes();
      test_toggle_fast_steps();
      test_random_short_phases();
      test_zero_phase_length();
      test_longest_phase();

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_lights.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bltl_pkg.sv
design/bltl_seq.sv
design/blinking_traffic_light_sequencer.sv
tb/tb_blinking_traffic_light_sequencer.sv
